@@ rtl/core/gdw_pkg.sv @@
`timescale 1ns / 1ps
package gdw_pkg;

  localparam int MaxNodes   = 64;
  localparam int MaxEdges   = 256;
  localparam int StackDepth = 128;

  localparam int OpW     = 3;
  localparam int InNodeW = 6;
  localparam int StatW   = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD_EDGE = 3'd0,
    OP_PUSH     = 3'd1,
    OP_ADVANCE  = 3'd2,
    OP_SKIP     = 3'd3,
    OP_RESTART  = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_VISITED  = 2'd1,
    ST_ENDED    = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_AT    = 2'd1,
    PH_ENDED = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_ADD_RD,
    S_ADD_WR,
    S_POP_RD,
    S_POP_CHK,
    S_HEAD_RD,
    S_EDGE_RD,
    S_DIS_RD,
    S_EDGE_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [InNodeW-1:0] from_node;
    logic [InNodeW-1:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [InNodeW-1:0] node_id;
  } out_item_t;

endpackage

@@ rtl/core/graph_dfs_walk_engine.sv @@
`timescale 1ns / 1ps
// Depth-first walk engine: one command per transaction while busy is low, one result
// strobed on done for a single cycle per command, in the first cycle after busy drops
// (the receiver cannot stall). After reset the node tables are swept with busy high
// and no result. Push and unused codes go straight to the result; add edge reads the
// head and tail of the source list and then writes the edge, or ends after the read
// when rejected; restart and clear-all sweep the node tables. An advance pops stack
// entries one at a time until it finds an unvisited node or the walk ends, then walks
// the successors of the visited node one at a time through the registered reads of
// the stack, edge and mark memories. Skip walks the successors in the same manner,
// or ends without a walk when there is no current node.
module graph_dfs_walk_engine import gdw_pkg::*; #(
  parameter int MAX_NODES   = MaxNodes,
  parameter int MAX_EDGES   = MaxEdges,
  parameter int STACK_DEPTH = StackDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  cmd,
  output logic      busy,
  output logic      done,
  output out_item_t result
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int SA = $clog2(STACK_DEPTH);
  localparam logic [EW-1:0] EMPTY = EW'(MAX_EDGES);

  // memories
  logic [NW-1:0] stack_mem [STACK_DEPTH];
  logic [NW-1:0] tgt_mem   [MAX_EDGES];
  logic [EW-1:0] link_mem  [MAX_EDGES];
  logic [EW-1:0] head_mem  [MAX_NODES];
  logic [EW-1:0] tail_mem  [MAX_NODES];
  logic          vis_mem   [MAX_NODES];
  logic          dis_mem   [MAX_NODES];

  state_t        state, state_next;
  in_item_t      item;
  phase_t        phase;
  logic [NW-1:0] cur;
  logic [SW-1:0] sdepth;
  logic [EW-1:0] ecount;
  logic [EW-1:0] eptr;
  logic [NW-1:0] clr_idx;
  logic          clr_edges;
  logic          boot;
  logic          dropped;
  logic          is_skip;
  status_t       res_stat;
  logic [NW-1:0] res_node;

  // registered reads
  logic [NW-1:0] stack_rd;
  logic [NW-1:0] tgt_rd;
  logic [EW-1:0] link_rd;
  logic [EW-1:0] head_rd;
  logic [EW-1:0] tail_rd;
  logic          vis_rd;
  logic          dis_rd;

  logic [NW-1:0] from_n;
  logic [NW-1:0] to_n;
  logic          from_ok;
  logic          to_ok;
  logic [NW-1:0] vis_addr;
  logic [NW-1:0] head_addr;

  assign from_n  = NW'(item.from_node);
  assign to_n    = NW'(item.to_node);
  assign from_ok = 32'(item.from_node) < MAX_NODES;
  assign to_ok   = 32'(item.to_node) < MAX_NODES;

  assign vis_addr  = (state == S_POP_CHK) ? stack_rd : cur;
  assign head_addr = (state == S_ADD_RD) ? from_n : cur;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd.operation)
            OP_ADD_EDGE: state_next = S_ADD_RD;
            OP_PUSH:     state_next = S_DONE;
            OP_ADVANCE:  state_next = S_POP_RD;
            OP_SKIP:     state_next = S_HEAD_RD;
            OP_RESTART:  state_next = S_CLR;
            OP_CLEAR:    state_next = S_CLR;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        if (clr_idx == NW'(MAX_NODES - 1)) state_next = boot ? S_IDLE : S_DONE;
      end
      S_ADD_RD:   state_next = S_ADD_WR;
      S_ADD_WR:   state_next = S_DONE;
      S_POP_RD:   state_next = S_POP_CHK;
      S_POP_CHK:  state_next = S_POP_RD;
      S_HEAD_RD:  state_next = S_EDGE_RD;
      S_EDGE_RD:  state_next = S_DIS_RD;
      S_DIS_RD:   state_next = S_EDGE_CHK;
      S_EDGE_CHK: state_next = S_EDGE_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
    // data dependent exits
    if (state == S_ADD_RD && (!from_ok || !to_ok || ecount >= EW'(MAX_EDGES)))
      state_next = S_DONE;
    if (state == S_POP_RD) begin
      if (phase == PH_ENDED) state_next = S_DONE;
      else if (phase == PH_AT && !vis_rd) state_next = S_HEAD_RD;
      else if (sdepth == '0) state_next = S_DONE;
    end
    if (state == S_HEAD_RD && is_skip && phase != PH_AT) state_next = S_DONE;
    if (state == S_EDGE_RD && (eptr >= ecount || eptr >= EW'(MAX_EDGES)))
      state_next = S_DONE;
  end

  always_ff @(posedge clk) begin
    vis_rd   <= vis_mem[vis_addr];
    stack_rd <= stack_mem[SA'(sdepth - SW'(1))];
    head_rd  <= head_mem[head_addr];
    tail_rd  <= tail_mem[from_n];
    tgt_rd   <= tgt_mem[EA'(eptr)];
    link_rd  <= link_mem[EA'(eptr)];
    dis_rd   <= dis_mem[tgt_rd];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      phase     <= PH_NONE;
      cur       <= '0;
      sdepth    <= '0;
      ecount    <= '0;
      clr_idx   <= '0;
      clr_edges <= 1'b1;
      boot      <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item      <= cmd;
            res_stat  <= ST_REJECTED;
            res_node  <= '0;
            dropped   <= 1'b0;
            is_skip   <= (cmd.operation == OP_SKIP);
            clr_idx   <= '0;
            clr_edges <= (cmd.operation == OP_CLEAR);
            if (cmd.operation == OP_RESTART || cmd.operation == OP_CLEAR) begin
              res_stat <= ST_ACCEPTED;
              phase    <= PH_NONE;
              cur      <= '0;
              sdepth   <= '0;
            end
            if (cmd.operation == OP_CLEAR) ecount <= '0;
            if (cmd.operation == OP_PUSH && 32'(cmd.from_node) < MAX_NODES &&
                32'(sdepth) < STACK_DEPTH) begin
              stack_mem[SA'(sdepth)] <= NW'(cmd.from_node);
              sdepth   <= sdepth + SW'(1);
              res_stat <= ST_ACCEPTED;
            end
          end
        end
        S_CLR: begin
          vis_mem[clr_idx] <= 1'b0;
          dis_mem[clr_idx] <= 1'b0;
          if (clr_edges) begin
            head_mem[clr_idx] <= EMPTY;
            tail_mem[clr_idx] <= EMPTY;
          end
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == NW'(MAX_NODES - 1)) boot <= 1'b0;
        end
        S_ADD_RD: ;
        S_ADD_WR: begin
          tgt_mem[EA'(ecount)]  <= to_n;
          link_mem[EA'(ecount)] <= EMPTY;
          if (head_rd == EMPTY || tail_rd >= EW'(MAX_EDGES))
            head_mem[from_n] <= ecount;
          else
            link_mem[EA'(tail_rd)] <= ecount;
          tail_mem[from_n] <= ecount;
          ecount   <= ecount + EW'(1);
          res_stat <= ST_ACCEPTED;
        end
        S_POP_RD: begin
          if (phase == PH_ENDED) begin
            res_stat <= ST_ENDED;
          end else if (phase == PH_AT && !vis_rd) begin
            vis_mem[cur] <= 1'b1;
            res_node     <= cur;
          end else if (sdepth == '0) begin
            phase    <= PH_ENDED;
            cur      <= '0;
            res_stat <= ST_ENDED;
          end else begin
            sdepth <= sdepth - SW'(1);
          end
        end
        S_POP_CHK: begin
          cur   <= stack_rd;
          phase <= PH_AT;
        end
        S_HEAD_RD: begin
          eptr <= head_rd;
          if (is_skip && phase == PH_AT) res_stat <= ST_ACCEPTED;
        end
        S_EDGE_RD: begin
          if (!is_skip && (eptr >= ecount || eptr >= EW'(MAX_EDGES)))
            res_stat <= dropped ? ST_REJECTED : ST_VISITED;
        end
        S_DIS_RD: ;
        S_EDGE_CHK: begin
          if (is_skip) begin
            vis_mem[tgt_rd] <= 1'b1;
          end else if (!dis_rd) begin
            if (32'(sdepth) < STACK_DEPTH) begin
              dis_mem[tgt_rd]        <= 1'b1;
              stack_mem[SA'(sdepth)] <= tgt_rd;
              sdepth                 <= sdepth + SW'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
          eptr <= link_rd;
        end
        S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assign result.status  = res_stat;
  assign result.node_id = InNodeW'(res_node);

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import gdw_pkg::*;

  localparam int NodeCount = 64;
  localparam int EdgeCap   = 256;
  localparam int StackCap  = 128;
  localparam int ListNil   = 256;
  localparam int CycleLimit = 3000000;

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  cmd;
  logic      busy;
  logic      done;
  out_item_t result;

  graph_dfs_walk_engine uut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // walk state mirror
  bit        vis[NodeCount];
  bit        disc[NodeCount];
  int        stk[StackCap];
  int        sdepth;
  int        etarget[EdgeCap];
  int        elink[EdgeCap];
  int        lhead[NodeCount];
  int        ltail[NodeCount];
  int        ecount;
  int        cur;
  phase_t    phase;

  in_item_t  cmd_queue[$];
  out_item_t result_queue[$];
  int        errors = 0;
  int        cycles = 0;
  bit        stim_done = 0;
  bit        calm = 0;

  function automatic void walk_reset();
    for (int i = 0; i < NodeCount; i++) begin
      vis[i] = 0;
      disc[i] = 0;
    end
    sdepth = 0;
    cur = 0;
    phase = PH_NONE;
  endfunction

  function automatic void edges_reset();
    for (int i = 0; i < NodeCount; i++) begin
      lhead[i] = ListNil;
      ltail[i] = ListNil;
    end
    ecount = 0;
  endfunction

  function automatic out_item_t walk_step(in_item_t c);
    out_item_t r;
    int        e;
    bit        dropped;
    r.status = ST_REJECTED;
    r.node_id = '0;
    case (c.operation)
      OP_ADD_EDGE: begin
        if (ecount < EdgeCap) begin
          etarget[ecount] = c.to_node;
          elink[ecount] = ListNil;
          if (lhead[c.from_node] == ListNil) begin
            lhead[c.from_node] = ecount;
          end else begin
            elink[ltail[c.from_node]] = ecount;
          end
          ltail[c.from_node] = ecount;
          ecount++;
          r.status = ST_ACCEPTED;
        end
      end
      OP_PUSH: begin
        if (sdepth < StackCap) begin
          stk[sdepth] = c.from_node;
          sdepth++;
          r.status = ST_ACCEPTED;
        end
      end
      OP_ADVANCE: begin
        if (phase == PH_ENDED) begin
          r.status = ST_ENDED;
        end else begin
          while (sdepth > 0 && (phase == PH_NONE || vis[cur])) begin
            sdepth--;
            cur = stk[sdepth];
            phase = PH_AT;
          end
          if (phase == PH_NONE || vis[cur]) begin
            phase = PH_ENDED;
            cur = 0;
            r.status = ST_ENDED;
          end else begin
            vis[cur] = 1;
            dropped = 0;
            e = lhead[cur];
            while (e < ecount) begin
              if (!disc[etarget[e]]) begin
                if (sdepth < StackCap) begin
                  disc[etarget[e]] = 1;
                  stk[sdepth] = etarget[e];
                  sdepth++;
                end else begin
                  dropped = 1;
                end
              end
              e = elink[e];
            end
            r.node_id = cur[5:0];
            r.status = dropped ? ST_REJECTED : ST_VISITED;
          end
        end
      end
      OP_SKIP: begin
        if (phase == PH_AT) begin
          e = lhead[cur];
          while (e < ecount) begin
            vis[etarget[e]] = 1;
            e = elink[e];
          end
          r.status = ST_ACCEPTED;
        end
      end
      OP_RESTART: begin
        walk_reset();
        r.status = ST_ACCEPTED;
      end
      OP_CLEAR: begin
        walk_reset();
        edges_reset();
        r.status = ST_ACCEPTED;
      end
      default: r.status = ST_REJECTED;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk(logic [2:0] op, int a, int b);
    in_item_t c;
    c.operation = op;
    c.from_node = a[5:0];
    c.to_node = b[5:0];
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd <= '0;
    end else begin
      if (start && !busy) begin
        result_queue.push_back(walk_step(cmd));
      end
      if ((start && busy) || (!(start && !busy) && start)) begin
        // hold current transaction
      end else if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        start <= 1'b1;
        cmd <= cmd_queue.pop_front();
      end else begin
        start <= 1'b0;
        cmd <= in_item_t'($urandom);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (result_queue.size() == 0) begin
        $error("result with no expectation: status %0d node %0d",
               result.status, result.node_id);
        errors++;
      end else begin
        want = result_queue.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, result.status);
          errors++;
        end
        if (result.node_id !== want.node_id) begin
          $error("node_id: expected %0d actual %0d", want.node_id, result.node_id);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_random_graph(int nodes, int edges);
    for (int i = 0; i < edges; i++) begin
      cmd_queue.push_back(mk(OP_ADD_EDGE, $urandom_range(nodes - 1),
                             $urandom_range(nodes - 1)));
    end
  endtask

  initial begin
    int pick;
    int n;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    walk_reset();
    edges_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty walk, skip without node, chain, extremes, bad codes
    cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));
    cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));
    cmd_queue.push_back(mk(OP_SKIP, 0, 0));
    cmd_queue.push_back(mk(OP_PUSH, 63, 0));
    cmd_queue.push_back(mk(OP_RESTART, 0, 0));
    cmd_queue.push_back(mk(OP_ADD_EDGE, 0, 63));
    cmd_queue.push_back(mk(OP_ADD_EDGE, 0, 1));
    cmd_queue.push_back(mk(OP_ADD_EDGE, 63, 2));
    cmd_queue.push_back(mk(OP_ADD_EDGE, 1, 2));
    cmd_queue.push_back(mk(OP_PUSH, 0, 0));
    cmd_queue.push_back(mk(OP_SKIP, 0, 0));
    cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));
    cmd_queue.push_back(mk(OP_SKIP, 0, 0));
    cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));
    cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));
    cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));
    cmd_queue.push_back(mk(OP_PUSH, 2, 0));
    cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));
    cmd_queue.push_back(mk(3'd6, 63, 63));
    cmd_queue.push_back(mk(3'd7, 0, 0));
    cmd_queue.push_back(mk(OP_CLEAR, 0, 0));
    cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));

    // full edge store, full stack on push and during advance
    for (int i = 0; i < 257; i++) begin
      cmd_queue.push_back(mk(OP_ADD_EDGE, i < 200 ? 0 : i % 64, (i + 1) % 64));
    end
    for (int i = 0; i < 129; i++) cmd_queue.push_back(mk(OP_PUSH, 63 - i % 64, 0));
    for (int i = 0; i < 80; i++) cmd_queue.push_back(mk(OP_ADVANCE, 0, 0));
    cmd_queue.push_back(mk(OP_CLEAR, 0, 0));

    // random walks over small graphs with noise
    for (int round = 0; round < 25; round++) begin
      n = $urandom_range(1, 4) == 1 ? 64 : $urandom_range(2, 16);
      add_random_graph(n, $urandom_range(0, 3 * n));
      repeat ($urandom_range(1, 3)) cmd_queue.push_back(mk(OP_PUSH, $urandom_range(n - 1), 0));
      repeat ($urandom_range(5, 25)) begin
        pick = $urandom_range(99);
        if (pick < 70) cmd_queue.push_back(mk(OP_ADVANCE, $urandom, $urandom));
        else if (pick < 82) cmd_queue.push_back(mk(OP_SKIP, $urandom, $urandom));
        else if (pick < 90) cmd_queue.push_back(mk(OP_PUSH, $urandom_range(n - 1), $urandom));
        else if (pick < 95) cmd_queue.push_back(mk(OP_ADD_EDGE, $urandom, $urandom));
        else if (pick < 98) cmd_queue.push_back(mk(OP_RESTART, $urandom, $urandom));
        else cmd_queue.push_back(mk(3'($urandom_range(6, 7)), $urandom, $urandom));
      end
      cmd_queue.push_back(mk($urandom_range(1) ? OP_CLEAR : OP_RESTART, $urandom, $urandom));
      if ($urandom_range(3) == 0) cmd_queue.push_back(mk(OP_CLEAR, 0, 0));
    end

    // stretch with no idling
    while (cmd_queue.size() > 300) @(posedge clk);
    calm = 1;
    while (cmd_queue.size() > 100) @(posedge clk);
    calm = 0;
    while (cmd_queue.size() > 0 || start) @(posedge clk);
    while (result_queue.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
